// ===== hw/rtl/touch_key_average_threshold_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Touch key averaging unit: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef TOUCH_KEY_AVERAGE_THRESHOLD_UNIT_MACROS_SVH
`define TOUCH_KEY_AVERAGE_THRESHOLD_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TKAT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TKAT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/tkat_pkg.sv =====
// ---------------------------------------------------------------------------
// Touch key averaging unit: package
// Widths, defaults and the round record passed from accumulation to
// evaluation.
// ---------------------------------------------------------------------------
package tkat_pkg;

  localparam int NUM_KEYS     = 4;
  localparam int READ_W       = 16;
  localparam int SUM_W        = 20;
  localparam int CNT_W        = 4;
  localparam int SAMPLES_DEF  = 15;
  localparam int CHANNELS_DEF = 4;

  localparam logic [READ_W-1:0] THRESH_RESET = 16'd15;

  typedef logic [NUM_KEYS-1:0][READ_W-1:0] tkat_read_t;
  typedef logic [NUM_KEYS-1:0][SUM_W-1:0]  tkat_sums_t;

  // A finished round of sums, waiting for evaluation.
  typedef struct packed {
    logic       valid;
    tkat_sums_t sum;
  } tkat_rnd_t;

endpackage

// ===== hw/rtl/tkat_accum.sv =====
// ---------------------------------------------------------------------------
// Touch key averaging unit: accumulator
// Adds each accepted word into the per-channel sums and, on the last word of a round,
// hands the completed sums to the evaluation stage through a round register.
// ---------------------------------------------------------------------------
`include "touch_key_average_threshold_unit_macros.svh"

module tkat_accum #(
  parameter int SAMPLES  = tkat_pkg::SAMPLES_DEF,
  parameter int CHANNELS = tkat_pkg::CHANNELS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tkat_pkg::tkat_read_t in_reading,
  output tkat_pkg::tkat_rnd_t  rnd,
  input  logic               rnd_take
);
  import tkat_pkg::*;

  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SAMPLES - 1);

  tkat_sums_t       sums_r, sums_nxt;
  tkat_sums_t       total;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             rnd_valid_r, rnd_valid_nxt;
  tkat_sums_t       rnd_sum_r, rnd_sum_nxt;
  logic             in_acc;
  logic             last;

  // The input waits only while a finished round cannot move on.
  assign in_stall = rnd_valid_r && !rnd_take;
  assign in_acc   = in_valid && !in_stall;
  assign last     = (cnt_r == LAST_CNT);

  assign rnd.valid = rnd_valid_r;
  assign rnd.sum   = rnd_sum_r;

  // Per-channel add; channels beyond the configured count stay at zero.
  always_comb begin
    for (int c = 0; c < NUM_KEYS; c++) begin
      if (c < CHANNELS) begin
        total[c] = sums_r[c] + SUM_W'(in_reading[c]);
      end else begin
        total[c] = '0;
      end
    end
  end

  // Round counting and hand-off of the completed sums.
  always_comb begin
    sums_nxt      = sums_r;
    cnt_nxt       = cnt_r;
    rnd_valid_nxt = rnd_take ? 1'b0 : rnd_valid_r;
    rnd_sum_nxt   = rnd_sum_r;
    if (in_acc) begin
      if (last) begin
        rnd_sum_nxt   = total;
        rnd_valid_nxt = 1'b1;
        sums_nxt      = '0;
        cnt_nxt       = '0;
      end else begin
        sums_nxt = total;
        cnt_nxt  = cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sums_r      <= '0;
      cnt_r       <= '0;
      rnd_valid_r <= 1'b0;
    end else begin
      sums_r      <= sums_nxt;
      cnt_r       <= cnt_nxt;
      rnd_valid_r <= rnd_valid_nxt;
    end
  end

  // Round payload needs no reset.
  always_ff @(posedge clk) begin
    rnd_sum_r <= rnd_sum_nxt;
  end

  `TKAT_ASSERT_SAME(a_cnt_range, 1'b1, cnt_r <= LAST_CNT, "round counter ran past the last round")
  `TKAT_ASSERT_NEXT(a_round_out, in_acc && last, rnd_valid_r, "completed round was not handed on")
  `TKAT_ASSERT_NEXT(a_sums_clear, in_acc && last, sums_r == '0, "sums not cleared after a round")
endmodule

// ===== hw/rtl/tkat_eval.sv =====
// ---------------------------------------------------------------------------
// Touch key averaging unit: evaluation
// Divides each round sum by the sample count, compares with the threshold,
// tracks held keys and drives the result register.
// ---------------------------------------------------------------------------
`include "touch_key_average_threshold_unit_macros.svh"

module tkat_eval #(
  parameter int SAMPLES  = tkat_pkg::SAMPLES_DEF,
  parameter int CHANNELS = tkat_pkg::CHANNELS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  tkat_pkg::tkat_rnd_t                  rnd,
  output logic                                 rnd_take,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tkat_pkg::READ_W-1:0]          cfg_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [tkat_pkg::NUM_KEYS-1:0]        out_pressed_mask,
  output logic [tkat_pkg::NUM_KEYS-1:0]        out_press_event_mask,
  output tkat_pkg::tkat_read_t                 out_average
);
  import tkat_pkg::*;

  // Division by the constant sample count as a reciprocal multiply. With
  // the shift at SUM_W plus the ceiling log2 of the divisor the result is exact
  // for every sum below 2**SUM_W.
  localparam int DIV_SH = SUM_W + $clog2(SAMPLES);
  localparam int MUL_W  = DIV_SH + 1;
  localparam int PROD_W = SUM_W + MUL_W;
  localparam logic [MUL_W-1:0] RECIP =
    MUL_W'(((64'd1 << DIV_SH) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES));
  localparam logic [NUM_KEYS-1:0] CH_MASK = NUM_KEYS'((1 << CHANNELS) - 1);

  logic [READ_W-1:0]   thresh_r;
  logic [NUM_KEYS-1:0] held_r, held_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [NUM_KEYS-1:0] pressed_r, events_r;
  tkat_read_t          avg_r;
  logic [PROD_W-1:0]   prod [NUM_KEYS];
  tkat_read_t          avg;
  logic [NUM_KEYS-1:0] press, events;
  logic                load;

  assign cfg_ready = 1'b1;

  // The result register takes a new round when empty or being drained.
  assign rnd_take = !out_valid_r || !out_stall;
  assign load     = rnd_take && rnd.valid;

  // Average, threshold compare and edge detect for each channel.
  always_comb begin
    for (int c = 0; c < NUM_KEYS; c++) begin
      prod[c] = PROD_W'(rnd.sum[c]) * PROD_W'(RECIP);
      if (c < CHANNELS) begin
        avg[c]   = prod[c][DIV_SH +: READ_W];
        press[c] = (avg[c] < thresh_r);
      end else begin
        avg[c]   = '0;
        press[c] = 1'b0;
      end
      events[c] = press[c] && !held_r[c];
    end
  end

  always_comb begin
    held_nxt      = load ? press : held_r;
    out_valid_nxt = rnd_take ? rnd.valid : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r    <= THRESH_RESET;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        thresh_r <= cfg_data;
      end
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload loads with each evaluated round.
  always_ff @(posedge clk) begin
    if (load) begin
      pressed_r <= press;
      events_r  <= events;
      avg_r     <= avg;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_pressed_mask     = pressed_r;
  assign out_press_event_mask = events_r;
  assign out_average          = avg_r;

  `TKAT_ASSERT_SAME(a_event_subset, out_valid_r, (events_r & ~pressed_r) == '0, "event on a key that is not pressed")
  `TKAT_ASSERT_NEXT(a_held_track, load, held_r == pressed_r, "held flags do not follow the last result")
  `TKAT_ASSERT_SAME(a_unused_keys, out_valid_r, (pressed_r & ~CH_MASK) == '0, "unused channel reported pressed")
endmodule

// ===== hw/rtl/touch_key_average_threshold_unit.sv =====
// A word that closes a round of SAMPLES words passes the round register, then the result register.
// Throughput: one word per cycle while in_stall is low; one result per SAMPLES words.
// The round register and the result register decouple input from output stalls.
// Reset (synchronous, rst_n low) clears sums, round count, held keys and valids;
// the threshold returns to 15.
// ---------------------------------------------------------------------------
// Touch key averaging unit: top level
// Accumulates scan rounds of four touch readings and reports averaged,
// thresholded key states with newly-pressed events.
// ---------------------------------------------------------------------------
module touch_key_average_threshold_unit #(
  parameter int SAMPLES  = tkat_pkg::SAMPLES_DEF,
  parameter int CHANNELS = tkat_pkg::CHANNELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tkat_pkg::READ_W-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tkat_pkg::READ_W-1:0]   in_reading_ch0,
  input  logic [tkat_pkg::READ_W-1:0]   in_reading_ch1,
  input  logic [tkat_pkg::READ_W-1:0]   in_reading_ch2,
  input  logic [tkat_pkg::READ_W-1:0]   in_reading_ch3,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tkat_pkg::NUM_KEYS-1:0] out_pressed_mask,
  output logic [tkat_pkg::NUM_KEYS-1:0] out_press_event_mask,
  output logic [tkat_pkg::READ_W-1:0]   out_average_ch0,
  output logic [tkat_pkg::READ_W-1:0]   out_average_ch1,
  output logic [tkat_pkg::READ_W-1:0]   out_average_ch2,
  output logic [tkat_pkg::READ_W-1:0]   out_average_ch3
);
  import tkat_pkg::*;

  tkat_read_t in_reading;
  tkat_read_t out_average;
  tkat_rnd_t  rnd;
  logic       rnd_take;

  assign in_reading = {in_reading_ch3, in_reading_ch2, in_reading_ch1, in_reading_ch0};

  // Per-channel accumulation over one round.
  tkat_accum #(
    .SAMPLES  (SAMPLES),
    .CHANNELS (CHANNELS)
  ) u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_reading (in_reading),
    .rnd        (rnd),
    .rnd_take   (rnd_take)
  );

  // Averaging, threshold and event detection.
  tkat_eval #(
    .SAMPLES  (SAMPLES),
    .CHANNELS (CHANNELS)
  ) u_eval (
    .clk                  (clk),
    .rst_n                (rst_n),
    .rnd                  (rnd),
    .rnd_take             (rnd_take),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_data             (cfg_data),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_pressed_mask     (out_pressed_mask),
    .out_press_event_mask (out_press_event_mask),
    .out_average          (out_average)
  );

  assign out_average_ch0 = out_average[0];
  assign out_average_ch1 = out_average[1];
  assign out_average_ch2 = out_average[2];
  assign out_average_ch3 = out_average[3];
endmodule
